>>> hdl/lcs_pkg.sv
// lcs_pkg: shared types and constants for the link connection supervisor
// holds state, event, error, mode and register index codes, plus word layouts
// no dependencies
package lcs_pkg;

  // link states
  typedef enum logic [2:0] {
    ST_DISABLED     = 3'd0,
    ST_INIT         = 3'd1,
    ST_WAITING      = 3'd2,
    ST_CONNECTED    = 3'd3,
    ST_DISCONNECTED = 3'd4,
    ST_ERROR        = 3'd5
  } lcs_state_t;

  // event codes reported with each result
  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_CONNECTED    = 3'd1,
    EV_LINK_LOST    = 3'd2,
    EV_ADDR_TIMEOUT = 3'd3,
    EV_MAX_RETRIES  = 3'd4,
    EV_RETRY        = 3'd5,
    EV_RESTORED     = 3'd6
  } lcs_event_t;

  // last error codes
  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_ADDR_TMO    = 2'd1,
    ERR_LINK_DOWN   = 2'd2,
    ERR_MAX_RETRIES = 2'd3
  } lcs_error_t;

  // input event kinds
  typedef enum logic [1:0] {
    MODE_TICK      = 2'd0,
    MODE_START     = 2'd1,
    MODE_RECONNECT = 2'd2,
    MODE_STOP      = 2'd3
  } lcs_mode_t;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_ADDR_TIMEOUT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_DELAY  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ATTEMPTS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CHECK_INTVL  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_AUTO_RETRY   = 3'd4;

  // register reset values
  localparam logic [31:0] ADDR_TIMEOUT_RST = 32'd30000;
  localparam logic [31:0] RETRY_DELAY_RST  = 32'd10000;
  localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd5;
  localparam logic [31:0] CHECK_INTVL_RST  = 32'd5000;

  localparam logic [7:0] ATTEMPT_MAX = 8'd255;

  // word widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 184;

  // configuration register set
  typedef struct packed {
    logic [31:0] address_timeout_ms;
    logic [31:0] retry_delay_ms;
    logic [7:0]  max_attempts;
    logic [31:0] check_interval_ms;
    logic        auto_retry;
  } lcs_cfg_t;

  // one result word, fields from the lowest bit up are listed last to first here
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] failed_total;
    logic [31:0] success_total;
    logic [31:0] retry_total;
    logic [31:0] timeout_total;
    logic [31:0] link_down_total;
    lcs_error_t  last_error;
    logic [7:0]  attempt_count;
    lcs_event_t  event_code;
    logic        state_changed;
    lcs_state_t  link_state;
  } lcs_result_t;

endpackage

>>> hdl/link_connection_supervisor_top.sv
// link_connection_supervisor_top: one event word in, one status word out per item
// each result is registered into the buffer's output register, or into its spare entry while the output waits
// throughput: one event word per cycle while the buffer has room; all checks are combinational compare logic
// a two-entry result buffer keeps input ready while one result waits downstream
// reset (rst, synchronous): state disabled, stopped, timers and counters zero,
// registers back to their defaults; no clearing pass is needed
module link_connection_supervisor_top (
  input  logic                          clk,
  input  logic                          rst,
  // event stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lcs_pkg::InDataW-1:0]   s_tdata,   // now_ms, link_up, address_valid, init_ok
  input  logic [1:0]                    s_tuser,   // mode
  // status stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lcs_pkg::OutDataW-1:0]  m_tdata,   // link_state, state_changed, event_code,
                                                   // attempt_count, last_error, link_down_total,
                                                   // timeout_total, retry_total, success_total,
                                                   // failed_total
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_data
);

  lcs_pkg::lcs_cfg_t    cfg;
  lcs_pkg::lcs_result_t result;
  logic                 accept;

  assign accept = s_tvalid && s_tready;

  // configuration registers
  lcs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // supervisor state machine
  lcs_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .accept        (accept),
    .mode          (lcs_pkg::lcs_mode_t'(s_tuser)),
    .now_ms        (s_tdata[31:0]),
    .link_up       (s_tdata[32]),
    .address_valid (s_tdata[33]),
    .init_ok       (s_tdata[34]),
    .result        (result)
  );

  // result buffer
  lcs_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_ready (s_tready),
    .push_data  (result),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata)
  );

endmodule

>>> hdl/lcs_cfg.sv
// lcs_cfg: configuration register file of the link connection supervisor
// decodes the write channel into the register set; depends on lcs_pkg
module lcs_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_data,
  output lcs_pkg::lcs_cfg_t             cfg
);

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.address_timeout_ms <= lcs_pkg::ADDR_TIMEOUT_RST;
      cfg.retry_delay_ms     <= lcs_pkg::RETRY_DELAY_RST;
      cfg.max_attempts       <= lcs_pkg::MAX_ATTEMPTS_RST;
      cfg.check_interval_ms  <= lcs_pkg::CHECK_INTVL_RST;
      cfg.auto_retry         <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lcs_pkg::CFG_ADDR_TIMEOUT: cfg.address_timeout_ms <= cfg_data;
        lcs_pkg::CFG_RETRY_DELAY:  cfg.retry_delay_ms     <= cfg_data;
        lcs_pkg::CFG_MAX_ATTEMPTS: cfg.max_attempts       <= cfg_data[7:0];
        lcs_pkg::CFG_CHECK_INTVL:  cfg.check_interval_ms  <= cfg_data;
        lcs_pkg::CFG_AUTO_RETRY:   cfg.auto_retry         <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/lcs_core.sv
// lcs_core: supervisor state machine, timers and event counters
// updates state on each accepted word and forms its result; depends on lcs_pkg
module lcs_core (
  input  logic                  clk,
  input  logic                  rst,
  input  lcs_pkg::lcs_cfg_t     cfg,
  input  logic                  accept,
  input  lcs_pkg::lcs_mode_t    mode,
  input  logic [31:0]           now_ms,
  input  logic                  link_up,
  input  logic                  address_valid,
  input  logic                  init_ok,
  output lcs_pkg::lcs_result_t  result
);

  lcs_pkg::lcs_state_t fsm_state, fsm_state_next;
  logic                running, running_next;
  logic [31:0]         last_check_time, last_check_time_next;
  logic [31:0]         state_entry_time, state_entry_time_next;
  logic [31:0]         last_retry_time, last_retry_time_next;
  logic [7:0]          attempts, attempts_next;
  lcs_pkg::lcs_error_t error_reg, error_reg_next;
  logic [31:0]         link_down_cnt, link_down_cnt_next;
  logic [31:0]         timeout_cnt, timeout_cnt_next;
  logic [31:0]         retry_cnt, retry_cnt_next;
  logic [31:0]         success_cnt, success_cnt_next;
  logic [31:0]         failed_cnt, failed_cnt_next;

  lcs_pkg::lcs_state_t eval_state;
  lcs_pkg::lcs_event_t ev;
  logic                changed;
  logic                check_due, retry_due, addr_expired;

  // modular time differences
  assign check_due    = (now_ms - last_check_time) >= cfg.check_interval_ms;
  assign retry_due    = cfg.auto_retry && ((now_ms - last_retry_time) > cfg.retry_delay_ms);
  assign addr_expired = (now_ms - state_entry_time) > cfg.address_timeout_ms;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm_state        <= lcs_pkg::ST_DISABLED;
      running          <= 1'b0;
      last_check_time  <= '0;
      state_entry_time <= '0;
      last_retry_time  <= '0;
      attempts         <= '0;
      error_reg        <= lcs_pkg::ERR_NONE;
      link_down_cnt    <= '0;
      timeout_cnt      <= '0;
      retry_cnt        <= '0;
      success_cnt      <= '0;
      failed_cnt       <= '0;
    end else if (accept) begin
      fsm_state        <= fsm_state_next;
      running          <= running_next;
      last_check_time  <= last_check_time_next;
      state_entry_time <= state_entry_time_next;
      last_retry_time  <= last_retry_time_next;
      attempts         <= attempts_next;
      error_reg        <= error_reg_next;
      link_down_cnt    <= link_down_cnt_next;
      timeout_cnt      <= timeout_cnt_next;
      retry_cnt        <= retry_cnt_next;
      success_cnt      <= success_cnt_next;
      failed_cnt       <= failed_cnt_next;
    end
  end

  // next state and counters for one event word
  always_comb begin
    fsm_state_next        = fsm_state;
    running_next          = running;
    last_check_time_next  = last_check_time;
    state_entry_time_next = state_entry_time;
    last_retry_time_next  = last_retry_time;
    attempts_next         = attempts;
    error_reg_next        = error_reg;
    link_down_cnt_next    = link_down_cnt;
    timeout_cnt_next      = timeout_cnt;
    retry_cnt_next        = retry_cnt;
    success_cnt_next      = success_cnt;
    failed_cnt_next       = failed_cnt;
    eval_state            = fsm_state;
    ev                    = lcs_pkg::EV_NONE;
    changed               = 1'b0;

    unique case (mode)
      lcs_pkg::MODE_TICK: begin
        if (running && check_due) begin
          last_check_time_next = now_ms;
          unique case (fsm_state)
            lcs_pkg::ST_ERROR: begin
              if (retry_due) begin
                last_retry_time_next = now_ms;
                if (attempts != lcs_pkg::ATTEMPT_MAX) attempts_next = attempts + 8'd1;
                retry_cnt_next = retry_cnt + 32'd1;
                if (init_ok) eval_state = lcs_pkg::ST_WAITING;
                else failed_cnt_next = failed_cnt + 32'd1;
                ev = lcs_pkg::EV_RETRY;
              end
            end
            lcs_pkg::ST_WAITING: begin
              if (address_valid) begin
                eval_state       = lcs_pkg::ST_CONNECTED;
                attempts_next    = '0;
                success_cnt_next = success_cnt + 32'd1;
                ev               = lcs_pkg::EV_CONNECTED;
              end else if (addr_expired) begin
                eval_state       = lcs_pkg::ST_ERROR;
                timeout_cnt_next = timeout_cnt + 32'd1;
                error_reg_next   = lcs_pkg::ERR_ADDR_TMO;
                ev               = lcs_pkg::EV_ADDR_TIMEOUT;
              end
            end
            lcs_pkg::ST_CONNECTED: begin
              if (!address_valid || !link_up) begin
                eval_state         = lcs_pkg::ST_DISCONNECTED;
                link_down_cnt_next = link_down_cnt + 32'd1;
                error_reg_next     = lcs_pkg::ERR_LINK_DOWN;
                ev                 = lcs_pkg::EV_LINK_LOST;
                if (cfg.auto_retry) begin
                  last_retry_time_next = now_ms;
                  attempts_next        = '0;
                end
              end
            end
            lcs_pkg::ST_DISCONNECTED: begin
              if (link_up) begin
                eval_state = lcs_pkg::ST_WAITING;
                ev         = lcs_pkg::EV_RESTORED;
              end else if (retry_due) begin
                last_retry_time_next = now_ms;
                if (attempts != lcs_pkg::ATTEMPT_MAX) attempts_next = attempts + 8'd1;
                retry_cnt_next = retry_cnt + 32'd1;
                if (init_ok) eval_state = lcs_pkg::ST_WAITING;
                else failed_cnt_next = failed_cnt + 32'd1;
                ev = lcs_pkg::EV_RETRY;
              end
              // attempt limit uses the count after this retry
              if (attempts_next > cfg.max_attempts) begin
                eval_state     = lcs_pkg::ST_ERROR;
                error_reg_next = lcs_pkg::ERR_MAX_RETRIES;
                ev             = lcs_pkg::EV_MAX_RETRIES;
              end
            end
            default: ;
          endcase
          if (eval_state != fsm_state) begin
            fsm_state_next        = eval_state;
            state_entry_time_next = now_ms;
            changed               = 1'b1;
          end
        end
      end
      lcs_pkg::MODE_START: begin
        if (!running) begin
          fsm_state_next       = init_ok ? lcs_pkg::ST_WAITING : lcs_pkg::ST_ERROR;
          last_check_time_next = now_ms;
          running_next         = 1'b1;
        end
      end
      lcs_pkg::MODE_RECONNECT: begin
        if (running) begin
          attempts_next        = '0;
          last_retry_time_next = '0;
          if (init_ok) begin
            fsm_state_next        = lcs_pkg::ST_WAITING;
            state_entry_time_next = now_ms;
          end else begin
            fsm_state_next = lcs_pkg::ST_ERROR;
          end
        end
      end
      lcs_pkg::MODE_STOP: begin
        running_next = 1'b0;
      end
      default: ;
    endcase
  end

  // result word for the event being accepted
  always_comb begin
    result                 = '0;
    result.link_state      = fsm_state_next;
    result.state_changed   = changed;
    result.event_code      = ev;
    result.attempt_count   = attempts_next;
    result.last_error      = error_reg_next;
    result.link_down_total = link_down_cnt_next;
    result.timeout_total   = timeout_cnt_next;
    result.retry_total     = retry_cnt_next;
    result.success_total   = success_cnt_next;
    result.failed_total    = failed_cnt_next;
  end

  // once started the machine never falls back to disabled
  a_running_not_disabled: assert property (@(posedge clk) disable iff (rst)
    running |-> fsm_state != lcs_pkg::ST_DISABLED)
    else $error("running with state disabled");

  // only tick evaluations report events or state changes
  a_event_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && (changed || ev != lcs_pkg::EV_NONE)) |-> mode == lcs_pkg::MODE_TICK)
    else $error("event reported on a non-tick word");

  // a stop always leaves the supervisor halted
  a_stop_halts: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == lcs_pkg::MODE_STOP) |=> !running)
    else $error("still running after stop");

  // counters move only on accepted words
  a_counters_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(retry_cnt) && $stable(failed_cnt) && $stable(attempts))
    else $error("counter moved without an accepted word");

endmodule

>>> hdl/lcs_skid.sv
// lcs_skid: two-entry result buffer between the core and the output stream
// keeps input ready while one result waits; depends on lcs_pkg
module lcs_skid (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          push_ready,
  input  logic [lcs_pkg::OutDataW-1:0]  push_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lcs_pkg::OutDataW-1:0]  out_data
);

  logic                          spare_valid;
  logic [lcs_pkg::OutDataW-1:0]  spare_data;
  logic                          pop;

  assign push_ready = !spare_valid;
  assign pop        = out_valid && out_ready;

  // control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      out_valid   <= spare_valid || push;
      spare_valid <= 1'b0;
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      out_data <= spare_valid ? spare_data : push_data;
    end else if (push) begin
      spare_data <= push_data;
    end
  end

  // spare entry is only used behind a waiting word
  a_spare_behind_main: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> out_valid)
    else $error("spare word without output word");

  // a waiting word is not replaced before it is taken
  a_hold_unless_taken: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // a full buffer refills the output from the spare entry
  a_refill: assert property (@(posedge clk) disable iff (rst)
    (spare_valid && pop) |=> out_valid && !spare_valid)
    else $error("spare word lost on refill");

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for link_connection_supervisor_top
// drives event words and register writes, predicts each status word in a scoreboard class
// depends on lcs_pkg and link_connection_supervisor_top
module tb_top;

  localparam int CYCLE_LIMIT = 200000;

  // status word predictor and in-order checker
  class status_scoreboard;
    logic [31:0]          addr_tmo, retry_dly, chk_intvl;
    logic [7:0]           max_att;
    logic                 auto_rty;
    lcs_pkg::lcs_state_t  st;
    logic                 running;
    logic [31:0]          last_chk, entry_t, last_rty;
    logic [7:0]           att;
    lcs_pkg::lcs_error_t  err;
    logic [31:0]          n_down, n_tmo, n_rty, n_ok, n_fail;
    lcs_pkg::lcs_result_t expected_q[$];
    int                   fails;

    function new();
      addr_tmo  = lcs_pkg::ADDR_TIMEOUT_RST;
      retry_dly = lcs_pkg::RETRY_DELAY_RST;
      max_att   = lcs_pkg::MAX_ATTEMPTS_RST;
      chk_intvl = lcs_pkg::CHECK_INTVL_RST;
      auto_rty  = 1'b1;
      st        = lcs_pkg::ST_DISABLED;
      running   = 1'b0;
      last_chk  = '0;
      entry_t   = '0;
      last_rty  = '0;
      att       = '0;
      err       = lcs_pkg::ERR_NONE;
      n_down    = '0;
      n_tmo     = '0;
      n_rty     = '0;
      n_ok      = '0;
      n_fail    = '0;
      fails     = 0;
    endfunction

    function void write_reg(logic [lcs_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
      case (idx)
        lcs_pkg::CFG_ADDR_TIMEOUT: addr_tmo  = data;
        lcs_pkg::CFG_RETRY_DELAY:  retry_dly = data;
        lcs_pkg::CFG_MAX_ATTEMPTS: max_att   = data[7:0];
        lcs_pkg::CFG_CHECK_INTVL:  chk_intvl = data;
        lcs_pkg::CFG_AUTO_RETRY:   auto_rty  = data[0];
        default: ;
      endcase
    endfunction

    // one reconnect attempt, stays put when reinit fails
    function lcs_pkg::lcs_state_t retry_attempt(logic [31:0] now, logic ok,
                                                lcs_pkg::lcs_state_t cur);
      last_rty = now;
      if (att != lcs_pkg::ATTEMPT_MAX) att = att + 8'd1;
      n_rty = n_rty + 32'd1;
      if (ok) return lcs_pkg::ST_WAITING;
      n_fail = n_fail + 32'd1;
      return cur;
    endfunction

    function void note_event(lcs_pkg::lcs_mode_t mode, logic [31:0] now, logic link,
                             logic addr, logic ok);
      lcs_pkg::lcs_result_t r;
      lcs_pkg::lcs_state_t  nxt;
      lcs_pkg::lcs_event_t  ev;
      logic                 chg;
      logic [31:0]          gap_chk, gap_rty, gap_entry;
      ev        = lcs_pkg::EV_NONE;
      chg       = 1'b0;
      gap_chk   = now - last_chk;
      gap_rty   = now - last_rty;
      gap_entry = now - entry_t;
      case (mode)
        lcs_pkg::MODE_TICK: begin
          if (running && gap_chk >= chk_intvl) begin
            last_chk = now;
            nxt = st;
            case (st)
              lcs_pkg::ST_ERROR: begin
                if (auto_rty && gap_rty > retry_dly) begin
                  nxt = retry_attempt(now, ok, nxt);
                  ev = lcs_pkg::EV_RETRY;
                end
              end
              lcs_pkg::ST_WAITING: begin
                if (addr) begin
                  nxt = lcs_pkg::ST_CONNECTED;
                  att = '0;
                  n_ok = n_ok + 32'd1;
                  ev = lcs_pkg::EV_CONNECTED;
                end else if (gap_entry > addr_tmo) begin
                  nxt = lcs_pkg::ST_ERROR;
                  n_tmo = n_tmo + 32'd1;
                  err = lcs_pkg::ERR_ADDR_TMO;
                  ev = lcs_pkg::EV_ADDR_TIMEOUT;
                end
              end
              lcs_pkg::ST_CONNECTED: begin
                if (!addr || !link) begin
                  nxt = lcs_pkg::ST_DISCONNECTED;
                  n_down = n_down + 32'd1;
                  err = lcs_pkg::ERR_LINK_DOWN;
                  ev = lcs_pkg::EV_LINK_LOST;
                  if (auto_rty) begin
                    last_rty = now;
                    att = '0;
                  end
                end
              end
              lcs_pkg::ST_DISCONNECTED: begin
                if (link) begin
                  nxt = lcs_pkg::ST_WAITING;
                  entry_t = now;
                  ev = lcs_pkg::EV_RESTORED;
                end else if (auto_rty && gap_rty > retry_dly) begin
                  nxt = retry_attempt(now, ok, nxt);
                  ev = lcs_pkg::EV_RETRY;
                end
                // attempt limit overrides whatever happened above
                if (att > max_att) begin
                  nxt = lcs_pkg::ST_ERROR;
                  err = lcs_pkg::ERR_MAX_RETRIES;
                  ev = lcs_pkg::EV_MAX_RETRIES;
                end
              end
              default: ;
            endcase
            if (nxt != st) begin
              st = nxt;
              entry_t = now;
              chg = 1'b1;
            end
          end
        end
        lcs_pkg::MODE_START: begin
          if (!running) begin
            st = ok ? lcs_pkg::ST_WAITING : lcs_pkg::ST_ERROR;
            last_chk = now;
            running = 1'b1;
          end
        end
        lcs_pkg::MODE_RECONNECT: begin
          if (running) begin
            att = '0;
            last_rty = '0;
            if (ok) begin
              st = lcs_pkg::ST_WAITING;
              entry_t = now;
            end else begin
              st = lcs_pkg::ST_ERROR;
            end
          end
        end
        default: begin
          running = 1'b0;
        end
      endcase
      r = '0;
      r.link_state      = st;
      r.state_changed   = chg;
      r.event_code      = ev;
      r.attempt_count   = att;
      r.last_error      = err;
      r.link_down_total = n_down;
      r.timeout_total   = n_tmo;
      r.retry_total     = n_rty;
      r.success_total   = n_ok;
      r.failed_total    = n_fail;
      expected_q.push_back(r);
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        fails++;
        if (fails <= 10) $display("mismatch %s: expected %0h got %0h", what, want, got);
      end
    endfunction

    function void check_status(lcs_pkg::lcs_result_t got);
      lcs_pkg::lcs_result_t want;
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("status word with nothing expected: %h", got);
        return;
      end
      want = expected_q.pop_front();
      compare("link_state", 32'(want.link_state), 32'(got.link_state));
      compare("state_changed", 32'(want.state_changed), 32'(got.state_changed));
      compare("event_code", 32'(want.event_code), 32'(got.event_code));
      compare("attempt_count", 32'(want.attempt_count), 32'(got.attempt_count));
      compare("last_error", 32'(want.last_error), 32'(got.last_error));
      compare("link_down_total", want.link_down_total, got.link_down_total);
      compare("timeout_total", want.timeout_total, got.timeout_total);
      compare("retry_total", want.retry_total, got.retry_total);
      compare("success_total", want.success_total, got.success_total);
      compare("failed_total", want.failed_total, got.failed_total);
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [lcs_pkg::InDataW-1:0]  s_tdata = '0;   // now_ms, link_up, address_valid, init_ok
  logic [1:0]                   s_tuser = '0;   // mode
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [lcs_pkg::OutDataW-1:0] m_tdata;        // link_state, state_changed, event_code,
                                                // attempt_count, last_error, link_down_total,
                                                // timeout_total, retry_total, success_total,
                                                // failed_total
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [lcs_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [31:0]                  cfg_data = '0;

  status_scoreboard sb = new();
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          cycle_cnt = 0;
  logic [31:0] clock_ms = '0;
  logic        link_s = 1'b1;
  logic        addr_s = 1'b1;

  link_connection_supervisor_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // handshake monitor: events in, status words out, register writes
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_event(lcs_pkg::lcs_mode_t'(s_tuser), s_tdata[31:0], s_tdata[32],
                      s_tdata[33], s_tdata[34]);
      if (m_tvalid && m_tready) sb.check_status(lcs_pkg::lcs_result_t'(m_tdata));
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // one event word, returns at the edge that takes it
  task send_event(lcs_pkg::lcs_mode_t mode, logic [31:0] now, logic link, logic addr,
                  logic ok);
    @(negedge clk);
    // idle cycles drawn one at a time
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tuser  <= mode;
    s_tdata  <= {5'b0, ok, addr, link, now};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task write_reg(logic [lcs_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop sending and let every expected word come back
  task wait_drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task apply_setting(logic [31:0] tmo, logic [31:0] rty, logic [7:0] max_a,
                     logic [31:0] chk, logic auto_r);
    wait_drain;
    write_reg(lcs_pkg::CFG_ADDR_TIMEOUT, tmo);
    write_reg(lcs_pkg::CFG_RETRY_DELAY, rty);
    write_reg(lcs_pkg::CFG_MAX_ATTEMPTS, {24'd0, max_a});
    write_reg(lcs_pkg::CFG_CHECK_INTVL, chk);
    write_reg(lcs_pkg::CFG_AUTO_RETRY, {31'd0, auto_r});
  endtask

  // mostly ticks on a running link with drifting flags, some commands and noise
  task traffic(int count, int unsigned step_cap);
    int          p;
    logic [31:0] now;
    clock_ms = $urandom;
    send_event(lcs_pkg::MODE_START, clock_ms, link_s, addr_s, 1'b1);
    repeat (count) begin
      p = $urandom_range(0, 99);
      if (p < 8) begin
        send_event(lcs_pkg::lcs_mode_t'(2'($urandom_range(0, 3))), $urandom,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end else if (p < 12) begin
        send_event(lcs_pkg::MODE_RECONNECT, clock_ms, link_s, addr_s,
                   $urandom_range(0, 3) != 0);
      end else if (p < 15) begin
        send_event(lcs_pkg::MODE_STOP, clock_ms, link_s, addr_s, 1'b1);
      end else if (p < 20) begin
        send_event(lcs_pkg::MODE_START, clock_ms, link_s, addr_s, $urandom_range(0, 3) != 0);
      end else begin
        // tick time: on the check boundary, just short of it, or a random step
        p = $urandom_range(0, 99);
        if (p < 12) now = sb.last_chk + sb.chk_intvl;
        else if (p < 16) now = sb.last_chk + sb.chk_intvl - 32'd1;
        else if (step_cap == 0) now = $urandom;
        else now = clock_ms + $urandom_range(0, step_cap);
        clock_ms = now;
        if ($urandom_range(0, 99) < 12) link_s = !link_s;
        if ($urandom_range(0, 99) < 12) addr_s = !addr_s;
        send_event(lcs_pkg::MODE_TICK, now, link_s, addr_s, $urandom_range(0, 4) != 0);
      end
    end
  endtask

  // failing reinit in error, long enough to pin the attempt counter
  task saturate_attempts(int count);
    send_event(lcs_pkg::MODE_STOP, clock_ms, 1'b0, 1'b0, 1'b0);
    send_event(lcs_pkg::MODE_START, clock_ms, 1'b0, 1'b0, 1'b0);
    repeat (count) begin
      clock_ms = clock_ms + $urandom_range(1, 50);
      send_event(lcs_pkg::MODE_TICK, clock_ms, 1'b0, 1'b0, 1'b0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver stalls often
    send_idle_pct = 19;
    stall_pct = 62;

    // directed walk through the states with reset register values
    send_event(lcs_pkg::MODE_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);   // tick while stopped
    send_event(lcs_pkg::MODE_STOP, 32'd0, 1'b0, 1'b0, 1'b0);           // stop while stopped
    send_event(lcs_pkg::MODE_RECONNECT, 32'd0, 1'b0, 1'b0, 1'b1);      // reconnect, stopped
    send_event(lcs_pkg::MODE_START, 32'd100, 1'b0, 1'b0, 1'b0);        // failed init, error
    send_event(lcs_pkg::MODE_START, 32'd150, 1'b1, 1'b1, 1'b1);        // start while running
    send_event(lcs_pkg::MODE_TICK, 32'd200, 1'b1, 1'b1, 1'b1);         // inside check interval
    send_event(lcs_pkg::MODE_TICK, 32'd20000, 1'b0, 1'b0, 1'b0);       // retry from error fails
    send_event(lcs_pkg::MODE_TICK, 32'd40000, 1'b0, 1'b0, 1'b1);       // retry succeeds
    send_event(lcs_pkg::MODE_TICK, 32'd80000, 1'b1, 1'b0, 1'b1);       // address timeout
    send_event(lcs_pkg::MODE_RECONNECT, 32'd81000, 1'b1, 1'b0, 1'b1);
    send_event(lcs_pkg::MODE_TICK, 32'd90000, 1'b1, 1'b1, 1'b1);       // connected
    send_event(lcs_pkg::MODE_TICK, 32'd96000, 1'b0, 1'b1, 1'b1);       // link lost
    send_event(lcs_pkg::MODE_TICK, 32'd110000, 1'b0, 1'b0, 1'b0);      // retry while down fails
    send_event(lcs_pkg::MODE_TICK, 32'd120000, 1'b1, 1'b0, 1'b1);      // link restored
    send_event(lcs_pkg::MODE_TICK, 32'd125000, 1'b1, 1'b1, 1'b1);
    send_event(lcs_pkg::MODE_TICK, 32'd130000, 1'b1, 1'b0, 1'b1);      // address lost
    send_event(lcs_pkg::MODE_RECONNECT, 32'd131000, 1'b0, 1'b0, 1'b0); // failed init
    send_event(lcs_pkg::MODE_STOP, 32'd132000, 1'b0, 1'b0, 1'b0);
    send_event(lcs_pkg::MODE_TICK, 32'd200000, 1'b1, 1'b1, 1'b1);
    send_event(lcs_pkg::MODE_START, 32'hFFFF_F000, 1'b1, 1'b0, 1'b1);
    send_event(lcs_pkg::MODE_TICK, 32'h0000_0400, 1'b1, 1'b0, 1'b1);   // time wraps, timeout

    apply_setting(32'd20000, 32'd3000, 8'd3, 32'd1000, 1'b1);
    traffic(25, 4000);

    // sender idles often, receiver stalls lightly
    send_idle_pct = 62;
    stall_pct = 19;
    apply_setting(32'd0, 32'd0, 8'd0, 32'd0, 1'b0);
    traffic(22, 5);
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF, 1'b1);
    traffic(22, 0);

    // no idling on either side
    send_idle_pct = 0;
    stall_pct = 0;
    apply_setting(32'd7000, 32'd1500, 8'd1, 32'd500, 1'b1);
    traffic(22, 2000);
    apply_setting(32'd100, 32'd0, 8'd255, 32'd0, 1'b1);
    saturate_attempts(260);
    traffic(15, 200);

    wait_drain;
    repeat (5) @(posedge clk);
    if (sb.fails == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
